// ----- hw/rtl/chc_pkg.sv -----
// ----------------------------------------------------------------------------
// chc_pkg
// Shared widths, constants, CORDIC angle table and control types for the
// compass heading and hard-iron calibration block.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int AXIS_W         = 16;  // raw and offset width
  localparam int FIELD_W        = 17;  // corrected axis width
  localparam int HEADING_W      = 16;
  localparam int CW             = 34;  // CORDIC x/y width
  localparam int ZW             = 34;  // angle accumulator width
  localparam int PRESCALE_SHIFT = 14;
  localparam int ANGLE_STEPS    = 16;
  localparam int ATAN_LEN       = 24;
  localparam int STEP_W         = $clog2(ATAN_LEN);

  localparam logic signed [AXIS_W-1:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] MAX_RESET = 16'sh8000;
  localparam logic [AXIS_W-1:0]        CAL_SAMPLES_RESET = 16'd500;

  // angle units are 1/65536 centidegree
  localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(64'sd18000 * 64'sd65536);
  localparam logic signed [ZW-1:0] Z_BIAS      = ZW'(64'sd36000 * 64'sd65536 + 64'sd32768);
  localparam logic [FIELD_W-1:0]   HEADING_MOD = FIELD_W'(36000);

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
    34'sd23437865,  34'sd11730358,  34'sd5866610,  34'sd2933484,
    34'sd1466764,   34'sd733385,    34'sd366693,   34'sd183346,
    34'sd91673,     34'sd45837,     34'sd22918,    34'sd11459,
    34'sd5730,      34'sd2865,      34'sd1432,     34'sd716,
    34'sd358,       34'sd179,       34'sd90,       34'sd45
  };

  // controller to datapath commands
  typedef struct packed {
    logic              take_start;
    logic              take_sample;
    logic              prep;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              finish;
    logic              load_out;
  } chc_cmd_t;

endpackage

// ----- hw/rtl/chc_ctrl.sv -----
// ----------------------------------------------------------------------------
// chc_ctrl
// Sequencer: accepts items, walks the CORDIC iterations and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module chc_ctrl import chc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_ready,
  input  logic     command,
  output logic     result_valid,
  input  logic     result_ready,
  output chc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              take, out_free;

  assign sample_ready = (state == S_IDLE);
  assign take         = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.step_idx  = step_cnt;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.take_sample = command;
          cmd.take_start  = !command;
          if (command) state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep      = 1'b1;
        step_cnt_next = '0;
        state_next    = S_RUN;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_W'(ANGLE_STEPS - 1)) begin
          state_next = S_FIN;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/chc_dp.sv -----
// ----------------------------------------------------------------------------
// chc_dp
// Datapath: offset correction, min/max tracking, iterative CORDIC vectoring
// and the output register.
// ----------------------------------------------------------------------------
module chc_dp import chc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  chc_cmd_t                    cmd,
  input  logic        [AXIS_W-1:0]    cal_samples,
  input  logic signed [AXIS_W-1:0]    raw_x,
  input  logic signed [AXIS_W-1:0]    raw_y,
  input  logic signed [AXIS_W-1:0]    raw_z,
  output logic signed [FIELD_W-1:0]   field_x,
  output logic signed [FIELD_W-1:0]   field_y,
  output logic signed [FIELD_W-1:0]   field_z,
  output logic        [HEADING_W-1:0] heading_centideg,
  output logic                        calibrating,
  output logic                        cal_done
);

  logic signed [AXIS_W-1:0]  raw     [3];
  logic signed [AXIS_W-1:0]  offset  [3];
  logic signed [AXIS_W-1:0]  min_ax  [3];
  logic signed [AXIS_W-1:0]  max_ax  [3];
  logic signed [AXIS_W-1:0]  min_n   [3];
  logic signed [AXIS_W-1:0]  max_n   [3];
  logic signed [AXIS_W:0]    mid_sum [3];
  logic signed [FIELD_W-1:0] corr_n  [3];
  logic signed [FIELD_W-1:0] corr    [3];
  logic [AXIS_W-1:0]         seen, seen_n;
  logic                      cal_active, cal_end;
  logic                      calib_flag, done_flag;

  logic signed [CW-1:0]      cx, cy, xs, ys, x_scaled, y_scaled;
  logic signed [ZW-1:0]      z, z_sum;
  logic                      zero_vec;
  logic [FIELD_W-1:0]        u, u_mod;
  logic [HEADING_W-1:0]      heading;

  assign raw[0] = raw_x;
  assign raw[1] = raw_y;
  assign raw[2] = raw_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      corr_n[k]  = {raw[k][AXIS_W-1], raw[k]} - {offset[k][AXIS_W-1], offset[k]};
      min_n[k]   = (raw[k] < min_ax[k]) ? raw[k] : min_ax[k];
      max_n[k]   = (raw[k] > max_ax[k]) ? raw[k] : max_ax[k];
      mid_sum[k] = {min_n[k][AXIS_W-1], min_n[k]} + {max_n[k][AXIS_W-1], max_n[k]};
    end
    seen_n  = seen + 1'b1;
    cal_end = (seen_n >= cal_samples);
  end

  // calibration state and corrected axes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_active <= 1'b0;
      seen       <= '0;
      for (int k = 0; k < 3; k++) begin
        offset[k] <= '0;
        min_ax[k] <= MIN_RESET;
        max_ax[k] <= MAX_RESET;
      end
    end else if (cmd.take_start) begin
      cal_active <= (cal_samples != '0);
      seen       <= '0;
      for (int k = 0; k < 3; k++) begin
        offset[k] <= '0;
        min_ax[k] <= MIN_RESET;
        max_ax[k] <= MAX_RESET;
      end
    end else if (cmd.take_sample && cal_active) begin
      seen <= seen_n;
      for (int k = 0; k < 3; k++) begin
        min_ax[k] <= min_n[k];
        max_ax[k] <= max_n[k];
        // floor of (max + min) / 2
        if (cal_end) offset[k] <= mid_sum[k][AXIS_W:1];
      end
      if (cal_end) cal_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      for (int k = 0; k < 3; k++) corr[k] <= corr_n[k];
      calib_flag <= cal_active;
      done_flag  <= cal_active && cal_end;
    end
  end

  // CORDIC vectoring, one step per cycle
  assign x_scaled = {{(CW-FIELD_W-PRESCALE_SHIFT){corr[0][FIELD_W-1]}}, corr[0],
                     {PRESCALE_SHIFT{1'b0}}};
  assign y_scaled = {{(CW-FIELD_W-PRESCALE_SHIFT){corr[1][FIELD_W-1]}}, corr[1],
                     {PRESCALE_SHIFT{1'b0}}};
  assign xs    = cx >>> cmd.step_idx;
  assign ys    = cy >>> cmd.step_idx;
  assign z_sum = z + Z_BIAS;
  assign u     = z_sum[FIELD_W+15:16];
  assign u_mod = (u >= HEADING_MOD) ? (u - HEADING_MOD) : u;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      zero_vec <= (corr[0] == '0) && (corr[1] == '0);
      if (corr[0][FIELD_W-1]) begin
        // left half plane: rotate by 180 degrees first
        cx <= -x_scaled;
        cy <= -y_scaled;
        z  <= Z_HALF_TURN;
      end else begin
        cx <= x_scaled;
        cy <= y_scaled;
        z  <= '0;
      end
    end else if (cmd.step) begin
      if (!cy[CW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        z  <= z + ATAN_TAB[cmd.step_idx];
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        z  <= z - ATAN_TAB[cmd.step_idx];
      end
    end
    if (cmd.finish) begin
      heading <= zero_vec ? '0 : u_mod[HEADING_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      field_x          <= corr[0];
      field_y          <= corr[1];
      field_z          <= corr[2];
      heading_centideg <= heading;
      calibrating      <= calib_flag;
      cal_done         <= done_flag;
    end
  end

endmodule

// ----- hw/rtl/compass_heading_hard_iron_cal.sv -----
// ----------------------------------------------------------------------------
// compass_heading_hard_iron_cal
// Hard-iron corrected magnetometer axes and atan2 heading with min/max
// offset calibration and an APB register for the calibration length.
// ----------------------------------------------------------------------------
// A sample item passes through prepare, 16 CORDIC iterations of the shared
//   shift-add unit, wrap and load; a start item keeps the block idle.
// Items are accepted only when idle, so a sample item is loaded before the
//   next one is accepted, even while the output register waits to be taken.
// Reset (synchronous, rst high): offsets 0, trackers cleared, no calibration
//   running, cal_samples = 500, no result pending.
module compass_heading_hard_iron_cal import chc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic        [2:0]           paddr,
  input  logic        [31:0]          pwdata,
  output logic        [31:0]          prdata,
  output logic                        pready,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic                        command,
  input  logic signed [AXIS_W-1:0]    raw_x,
  input  logic signed [AXIS_W-1:0]    raw_y,
  input  logic signed [AXIS_W-1:0]    raw_z,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [FIELD_W-1:0]   field_x,
  output logic signed [FIELD_W-1:0]   field_y,
  output logic signed [FIELD_W-1:0]   field_z,
  output logic        [HEADING_W-1:0] heading_centideg,
  output logic                        calibrating,
  output logic                        cal_done
);

  logic [AXIS_W-1:0] cal_samples;
  chc_cmd_t          cmd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-AXIS_W){1'b0}}, cal_samples};

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cal_samples <= pwdata[AXIS_W-1:0];
    end
  end

  chc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .command      (command),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  chc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cal_samples      (cal_samples),
    .raw_x            (raw_x),
    .raw_y            (raw_y),
    .raw_z            (raw_z),
    .field_x          (field_x),
    .field_y          (field_y),
    .field_z          (field_z),
    .heading_centideg (heading_centideg),
    .calibrating      (calibrating),
    .cal_done         (cal_done)
  );

endmodule

// ----- hw/rtl/chc_checker.sv -----
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks for the compass heading block, bound to the top level.
// ----------------------------------------------------------------------------
module chc_checker import chc_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_ready,
  input logic                        command,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic signed [FIELD_W-1:0]   field_x,
  input logic signed [FIELD_W-1:0]   field_y,
  input logic        [HEADING_W-1:0] heading_centideg,
  input logic                        calibrating,
  input logic                        cal_done
);

  // a stalled result holds its heading
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(heading_centideg))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> heading_centideg < HEADING_W'(36000))
    else $error("heading out of range");

  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && cal_done |-> calibrating)
    else $error("cal_done without calibrating");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && field_x == '0 && field_y == '0 |-> heading_centideg == '0)
    else $error("zero vector with nonzero heading");

  // a start item leaves the input ready again
  a_start: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && !command |=> sample_ready)
    else $error("start item stalled input");

endmodule

bind compass_heading_hard_iron_cal chc_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample_valid),
  .sample_ready     (sample_ready),
  .command          (command),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .field_x          (field_x),
  .field_y          (field_y),
  .heading_centideg (heading_centideg),
  .calibrating      (calibrating),
  .cal_done         (cal_done)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compass heading and hard-iron calibration block.
// A local predictor tracks offsets, min/max trackers and the calibration run,
// and works out the corrected axes and CORDIC heading for every sample item.
// Results are compared field by field in order while both handshakes idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb import chc_pkg::*;;

  localparam logic       CMD_START        = 1'b0;
  localparam logic       CMD_SAMPLE       = 1'b1;
  localparam logic [2:0] ADDR_CAL_SAMPLES = 3'd0;
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;
  localparam int         HOLD_CYCLES      = 400;
  localparam int         SETTLE_CYCLES    = 30;
  localparam int         RANDOM_ITEMS     = 400;

  // atan(2^-i) in 1/65536 centidegree
  localparam longint ARCTAN_STEP [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };
  localparam longint HALF_TURN  = 64'sd18000 * 64'sd65536;
  localparam longint TURN_BIAS  = 64'sd36000 * 64'sd65536 + 64'sd32768;

  typedef struct packed {
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic [HEADING_W-1:0]      heading;
    logic                      cal;
    logic                      done;
  } compass_fix_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [2:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        sample_valid;
  logic                        sample_ready;
  logic                        command;
  logic signed [AXIS_W-1:0]    raw_x;
  logic signed [AXIS_W-1:0]    raw_y;
  logic signed [AXIS_W-1:0]    raw_z;
  logic                        result_valid;
  logic                        result_ready;
  logic signed [FIELD_W-1:0]   field_x;
  logic signed [FIELD_W-1:0]   field_y;
  logic signed [FIELD_W-1:0]   field_z;
  logic [HEADING_W-1:0]        heading_centideg;
  logic                        calibrating;
  logic                        cal_done;

  // predictor state
  int           off_x, off_y, off_z;
  int           axis_lo [3];
  int           axis_hi [3];
  int           n_seen;
  bit           cal_on;
  int           cal_len;
  compass_fix_t fix_queue [$];

  int           errors;
  int           burst_left;
  bit           steady;
  bit           hold_req;

  compass_heading_hard_iron_cal u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .command          (command),
    .raw_x            (raw_x),
    .raw_y            (raw_y),
    .raw_z            (raw_z),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .field_x          (field_x),
    .field_y          (field_y),
    .field_z          (field_z),
    .heading_centideg (heading_centideg),
    .calibrating      (calibrating),
    .cal_done         (cal_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HEADING_W-1:0] calc_heading(input int fx, input int fy);
    longint x, y, acc, xs, ys;
    int     i;
    if (fx == 0 && fy == 0) return '0;
    x   = longint'(fx) * 16384;
    y   = longint'(fy) * 16384;
    acc = 0;
    // fold the left half-plane onto the right one
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = HALF_TURN;
    end
    for (i = 0; i < ANGLE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + ARCTAN_STEP[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - ARCTAN_STEP[i];
      end
    end
    acc = acc + TURN_BIAS;
    if (acc < 0) acc = 0;
    return HEADING_W'((acc >>> 16) % 36000);
  endfunction

  task automatic clear_cal_state();
    int k;
    off_x  = 0;
    off_y  = 0;
    off_z  = 0;
    for (k = 0; k < 3; k++) begin
      axis_lo[k] = 32767;
      axis_hi[k] = -32768;
    end
    n_seen = 0;
  endtask

  task automatic apply_item(input logic cmd, input logic signed [AXIS_W-1:0] x,
                            input logic signed [AXIS_W-1:0] y,
                            input logic signed [AXIS_W-1:0] z);
    int           r [3];
    int           k;
    compass_fix_t f;
    if (cmd == CMD_START) begin
      clear_cal_state();
      cal_on = (cal_len != 0);
      return;
    end
    r[0]      = int'(x);
    r[1]      = int'(y);
    r[2]      = int'(z);
    f.fx      = FIELD_W'(r[0] - off_x);
    f.fy      = FIELD_W'(r[1] - off_y);
    f.fz      = FIELD_W'(r[2] - off_z);
    f.heading = calc_heading(r[0] - off_x, r[1] - off_y);
    f.cal     = 1'b0;
    f.done    = 1'b0;
    if (cal_on) begin
      f.cal = 1'b1;
      for (k = 0; k < 3; k++) begin
        if (r[k] < axis_lo[k]) axis_lo[k] = r[k];
        if (r[k] > axis_hi[k]) axis_hi[k] = r[k];
      end
      n_seen = (n_seen + 1) & 16'hFFFF;
      // the new offsets apply from the next sample on
      if (n_seen >= cal_len) begin
        off_x  = (axis_hi[0] + axis_lo[0]) >>> 1;
        off_y  = (axis_hi[1] + axis_lo[1]) >>> 1;
        off_z  = (axis_hi[2] + axis_lo[2]) >>> 1;
        cal_on = 1'b0;
        f.done = 1'b1;
      end
    end
    fix_queue.push_back(f);
  endtask

  task automatic send_item(input logic cmd, input logic signed [AXIS_W-1:0] x,
                           input logic signed [AXIS_W-1:0] y,
                           input logic signed [AXIS_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = steady ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_valid <= 1'b1;
    command      <= cmd;
    raw_x        <= x;
    raw_y        <= y;
    raw_z        <= z;
    do @(posedge clk); while (sample_ready !== 1'b1);
    apply_item(cmd, x, y, z);
  endtask

  task automatic send_sample(input int x, input int y, input int z);
    send_item(CMD_SAMPLE, AXIS_W'(x), AXIS_W'(y), AXIS_W'(z));
  endtask

  task automatic send_start();
    send_item(CMD_START, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
  endtask

  // drop valid, drain all results, then let the block settle
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (fix_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_CAL_SAMPLES) cal_len = data[15:0];
  endtask

  task automatic check_cal_len();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CAL_SAMPLES;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata[15:0] !== 16'(cal_len)) begin
      $error("cal_samples readback: expected %0d, actual %0d", cal_len, prdata[15:0]);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    compass_fix_t want;
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1) begin
      if (fix_queue.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = fix_queue.pop_front();
        if (field_x !== want.fx) begin
          $error("field_x: expected %0d, actual %0d", want.fx, field_x);
          errors++;
        end
        if (field_y !== want.fy) begin
          $error("field_y: expected %0d, actual %0d", want.fy, field_y);
          errors++;
        end
        if (field_z !== want.fz) begin
          $error("field_z: expected %0d, actual %0d", want.fz, field_z);
          errors++;
        end
        if (heading_centideg !== want.heading) begin
          $error("heading_centideg: expected %0d, actual %0d", want.heading,
                 heading_centideg);
          errors++;
        end
        if (calibrating !== want.cal) begin
          $error("calibrating: expected %0d, actual %0d", want.cal, calibrating);
          errors++;
        end
        if (cal_done !== want.done) begin
          $error("cal_done: expected %0d, actual %0d", want.done, cal_done);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result sink: stall patterns change every so often; a hold-off request
  // keeps ready low for a long stretch
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int span;
    int held;
    result_ready = 1'b0;
    mode         = 0;
    span         = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req      = 1'b0;
        result_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 150);
        end
        span--;
        case (mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= $urandom_range(0, 1);
          2:       result_ready <= (span % 7) >= 3;
          default: result_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_headings();
    check_cal_len();
    send_sample(0, 0, 0);
    send_sample(1, 0, 5);
    send_sample(0, 1, -5);
    send_sample(-1, 0, 0);
    send_sample(0, -1, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(-32768, 32767, 0);
    send_sample(32767, -32768, -1);
    send_sample(-3, -4, 1);
    wait_idle();
  endtask

  // offsets at both ends of the range push the corrected axes to their limits
  task automatic test_offset_extremes();
    write_reg(ADDR_CAL_SAMPLES, {16'($urandom), 16'd2});
    check_cal_len();
    send_start();
    send_sample(-32768, -32768, -32768);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_start();
    send_sample(32767, 32767, 32767);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    // odd min+max sums round toward minus infinity
    send_start();
    send_sample(-32768, 32767, -1);
    send_sample(32767, -32768, 0);
    send_sample(-1, -1, -1);
    wait_idle();
  endtask

  task automatic test_zero_length();
    write_reg(ADDR_CAL_SAMPLES, 32'd0);
    send_start();
    send_sample(100, -200, 300);
    wait_idle();
    write_reg(ADDR_CAL_SAMPLES, 32'd1);
    send_start();
    send_sample(400, -600, 20);
    send_sample(400, -600, 20);
    wait_idle();
  endtask

  task automatic test_restart();
    write_reg(ADDR_CAL_SAMPLES, 32'd4);
    send_start();
    send_sample(1000, 2000, 3000);
    send_sample(-1000, -2000, -3000);
    send_start();
    send_sample(50, 60, 70);
    send_sample(-70, 10, 700);
    send_sample(20, -90, 5);
    send_sample(0, 0, 0);
    send_sample(10, 10, 10);
    wait_idle();
  endtask

  task automatic test_length_lowered();
    write_reg(ADDR_CAL_SAMPLES, 32'hFFFF);
    check_cal_len();
    send_start();
    send_sample(300, 200, 100);
    send_sample(-300, -200, -100);
    send_sample(30, 20, 10);
    wait_idle();
    write_reg(ADDR_CAL_SAMPLES, 32'd2);
    send_sample(600, -400, 0);
    send_sample(600, -400, 0);
    wait_idle();
  endtask

  task automatic test_unused_address();
    write_reg(ADDR_UNUSED, $urandom);
    check_cal_len();
    send_sample(-12, 345, 6);
    wait_idle();
  endtask

  task automatic test_output_stall();
    int k;
    steady   = 1'b1;
    hold_req = 1'b1;
    for (k = 0; k < 8; k++)
      send_sample($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic(input int target);
    int sent;
    int len;
    int n;
    int k;
    int x, y;
    sent = 0;
    while (sent < target) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 1;
        2:       len = 2;
        default: len = $urandom_range(1, 24);
      endcase
      write_reg(ADDR_CAL_SAMPLES, {16'($urandom), 16'(len)});
      if ($urandom_range(0, 3) == 0) check_cal_len();
      n = len + $urandom_range(0, 8);
      // mostly a start followed by a full run; sometimes no start at all
      if ($urandom_range(0, 4) != 0) begin
        send_start();
        sent++;
      end
      for (k = 0; k < n && sent < target; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          send_start();
        end else begin
          case ($urandom_range(0, 7))
            0: begin
              x = off_x;
              y = off_y;
            end
            1: begin
              x = off_x + int'($urandom_range(0, 60)) - 30;
              y = off_y;
            end
            2: begin
              x = off_x;
              y = off_y + int'($urandom_range(0, 60)) - 30;
            end
            3: begin
              x = off_x + int'($urandom_range(0, 1000)) - 500;
              y = off_y + int'($urandom_range(0, 1000)) - 500;
            end
            default: begin
              x = $urandom;
              y = $urandom;
            end
          endcase
          send_sample(x, y, $urandom);
        end
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    command      = CMD_SAMPLE;
    raw_x        = '0;
    raw_y        = '0;
    raw_z        = '0;
    errors       = 0;
    burst_left   = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    cal_len      = 500;
    cal_on       = 1'b0;
    clear_cal_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_headings();
    test_offset_extremes();
    test_zero_length();
    test_restart();
    test_length_lowered();
    test_unused_address();
    test_output_stall();
    test_random_traffic(RANDOM_ITEMS);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
